>>> hw/rtl/dctf_pkg.sv
// ----------------------------------------------------------------------------
// dctf_pkg: disk controller task file definitions
// Shared types, codes and default sizes for the task-file unit.
// ----------------------------------------------------------------------------
package dctf_pkg;

  // Default sizes and limits
  localparam int unsigned SectorBytesDef = 512;
  localparam int unsigned MaxTrackLowDef = 255;
  localparam int unsigned MaxSectorDef   = 16;

  // Field widths
  localparam int unsigned OffsetW = 31;

  // Item commands on the input channel
  typedef enum logic [2:0] {
    ITEM_REG_WRITE  = 3'd0,
    ITEM_REG_READ   = 3'd1,
    ITEM_DISK_FILL  = 3'd2,
    ITEM_DISK_DRAIN = 3'd3,
    ITEM_DISK_DONE  = 3'd4
  } item_cmd_e;

  // Task-file register indexes
  typedef enum logic [2:0] {
    REG_DATA       = 3'd0,
    REG_ERROR      = 3'd1,
    REG_COUNT      = 3'd2,
    REG_SECTOR     = 3'd3,
    REG_TRACK_LOW  = 3'd4,
    REG_TRACK_HIGH = 3'd5,
    REG_SDH        = 3'd6,
    REG_STATUS     = 3'd7
  } reg_idx_e;

  // Controller command codes
  localparam logic [7:0] CmdRestore = 8'h10;
  localparam logic [7:0] CmdRead    = 8'h20;
  localparam logic [7:0] CmdWrite   = 8'h30;

  // Value returned for an absent drive
  localparam logic [7:0] AbsentValue = 8'hFF;

  // Configuration register indexes
  localparam logic CfgDrive0 = 1'b0;
  localparam logic CfgDrive1 = 1'b1;

  // Active operation
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_RESTORE = 2'd1,
    OP_READ    = 2'd2,
    OP_WRITE   = 2'd3
  } op_e;

  // Disk transfer kind, also the disk_request code
  typedef enum logic [1:0] {
    XFER_NONE  = 2'd0,
    XFER_READ  = 2'd1,
    XFER_WRITE = 2'd2
  } xfer_e;

  // One result beat
  typedef struct packed {
    logic [7:0]         read_data;
    logic [1:0]         disk_request;
    logic               disk_drive;
    logic [OffsetW-1:0] disk_offset;
  } result_t;

endpackage

>>> hw/rtl/disk_controller_task_file_unit.sv
// ----------------------------------------------------------------------------
// disk_controller_task_file_unit: hard-disk controller task file
// Task-file registers, sector buffer and disk transfer requests.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i/in_stall_o  | command, reg_index, data, disk_ok
//  out     | output    | out_valid_o/out_stall_i| read_data, disk_request,
//          |           |                        | disk_drive, disk_offset
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One beat per cycle in while in_stall_o is low, one result per beat out:
// the buffer read port and stage one are registered, then the result enters
// the output register. A second result stage lets one more beat in while the
// output is stalled. After reset a clearing pass loads the buffer with its
// index pattern; in_stall_o is high while it runs.
// Configuration writes are taken in any cycle.

module disk_controller_task_file_unit #(
  parameter int unsigned SectorBytes = dctf_pkg::SectorBytesDef,
  parameter int unsigned MaxTrackLow = dctf_pkg::MaxTrackLowDef,
  parameter int unsigned MaxSector   = dctf_pkg::MaxSectorDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic [2:0]                   reg_index_i,
  input  logic [7:0]                   data_i,
  input  logic                         disk_ok_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   read_data_o,
  output logic [1:0]                   disk_request_o,
  output logic                         disk_drive_o,
  output logic [dctf_pkg::OffsetW-1:0] disk_offset_o,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic                         cfg_data_i
);

  localparam int unsigned AddrW = $clog2(SectorBytes);
  localparam int unsigned PtrW  = $clog2(SectorBytes + 1);
  localparam logic [PtrW-1:0]  FullPtr   = PtrW'(SectorBytes);
  localparam logic [AddrW-1:0] LastAddr  = AddrW'(SectorBytes - 1);
  localparam logic [7:0]       TrackLim  = 8'(MaxTrackLow);
  localparam logic [7:0]       SectorLim = 8'(MaxSector);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [PtrW-1:0]  bp_q, bp_d;
  logic [PtrW-1:0]  tp_q, tp_d;
  dctf_pkg::op_e    op_q, op_d;
  dctf_pkg::xfer_e  pend_q, pend_d;
  logic [7:0]       track_low_q, track_low_d;
  logic [7:0]       track_high_q, track_high_d;
  logic [7:0]       sector_q, sector_d;
  logic [7:0]       count_q, count_d;
  logic [7:0]       sdh_q, sdh_d;
  logic [7:0]       cmd_code_q, cmd_code_d;
  logic [7:0]       precomp_q, precomp_d;
  logic             ready_q, ready_d;
  logic             drq_q, drq_d;
  logic             seek_q, seek_d;
  logic             drive0_q, drive1_q;

  // clearing pass
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;

  // result stages
  logic              s1_valid_q;
  dctf_pkg::result_t s1_q, s1_d;
  logic              s1_mem_q, s1_mem_d;
  logic              out_valid_q;
  dctf_pkg::result_t out_q;
  logic              s2_load;
  logic              in_accept;

  // buffer ports
  logic [7:0]       mem [SectorBytes];
  logic [7:0]       rd_q;
  logic             mem_we, item_we;
  logic [AddrW-1:0] mem_wa, item_wa;
  logic [7:0]       mem_wd, item_wd;
  logic             mem_re;
  logic [AddrW-1:0] mem_ra;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign s2_load     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = clr_busy_q || (s1_valid_q && !s2_load);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Drive selection and linear offset
  // --------------------------------------------------------------------------
  logic                         sel_drive;
  logic                         sel_present;
  logic [2:0]                   head_adj;
  logic [7:0]                   sec_adj;
  logic [dctf_pkg::OffsetW-1:0] lin_offset;
  logic [PtrW-1:0]              bp_inc, tp_inc;
  logic [7:0]                   status_val;

  assign sel_drive   = (sdh_q[2:0] >= 3'd2);
  assign sel_present = sel_drive ? drive1_q : drive0_q;
  assign head_adj    = sel_drive ? (sdh_q[2:0] - 3'd2) : sdh_q[2:0];
  assign sec_adj     = (sector_q != 8'd0) ? (sector_q - 8'd1) : 8'd0;
  assign lin_offset  = {1'b0, track_high_q, track_low_q, 14'b0}
                     + {15'b0, head_adj, 13'b0}
                     + {14'b0, sec_adj, 9'b0};
  assign bp_inc      = bp_q + PtrW'(1);
  assign tp_inc      = tp_q + PtrW'(1);
  assign status_val  = {1'b0, ready_q, 1'b0, seek_q, drq_q, 3'b0};

  // --------------------------------------------------------------------------
  // Item processing
  // --------------------------------------------------------------------------
  always_comb begin
    bp_d         = bp_q;
    tp_d         = tp_q;
    op_d         = op_q;
    pend_d       = pend_q;
    track_low_d  = track_low_q;
    track_high_d = track_high_q;
    sector_d     = sector_q;
    count_d      = count_q;
    sdh_d        = sdh_q;
    cmd_code_d   = cmd_code_q;
    precomp_d    = precomp_q;
    ready_d      = ready_q;
    drq_d        = drq_q;
    seek_d       = seek_q;
    s1_d         = '0;
    s1_mem_d     = 1'b0;
    item_we      = 1'b0;
    item_wa      = bp_q[AddrW-1:0];
    item_wd      = data_i;
    mem_re       = 1'b0;
    mem_ra       = bp_q[AddrW-1:0];

    if (in_accept) begin
      unique case (dctf_pkg::item_cmd_e'(command_i))
        dctf_pkg::ITEM_REG_WRITE: begin
          unique case (dctf_pkg::reg_idx_e'(reg_index_i))
            dctf_pkg::REG_DATA: begin
              if (bp_q < FullPtr) begin
                item_we = 1'b1;
                bp_d    = bp_inc;
                if (bp_inc >= FullPtr) begin
                  drq_d = 1'b0;
                  if (op_q == dctf_pkg::OP_WRITE && sel_present) begin
                    pend_d            = dctf_pkg::XFER_WRITE;
                    tp_d              = '0;
                    s1_d.disk_request = dctf_pkg::XFER_WRITE;
                    s1_d.disk_drive   = sel_drive;
                    s1_d.disk_offset  = lin_offset;
                  end else begin
                    ready_d = 1'b0;
                  end
                  op_d = dctf_pkg::OP_NONE;
                end
              end
            end
            dctf_pkg::REG_ERROR:      precomp_d    = data_i;
            dctf_pkg::REG_COUNT:      count_d      = data_i;
            dctf_pkg::REG_SECTOR:     sector_d     = data_i;
            dctf_pkg::REG_TRACK_LOW:  track_low_d  = data_i;
            dctf_pkg::REG_TRACK_HIGH: track_high_d = data_i;
            dctf_pkg::REG_SDH:        sdh_d        = data_i;
            dctf_pkg::REG_STATUS: begin
              // command write always cancels a pending transfer
              cmd_code_d = data_i;
              pend_d     = dctf_pkg::XFER_NONE;
              tp_d       = '0;
              if (!sel_present) begin
                op_d   = dctf_pkg::OP_NONE;
                drq_d  = 1'b0;
                seek_d = 1'b0;
              end else begin
                ready_d = 1'b1;
                unique case (data_i)
                  dctf_pkg::CmdRestore: begin
                    op_d        = dctf_pkg::OP_RESTORE;
                    track_low_d = 8'd0;
                    sector_d    = 8'd0;
                    bp_d        = '0;
                    seek_d      = 1'b0;
                    drq_d       = 1'b0;
                  end
                  dctf_pkg::CmdRead: begin
                    if (track_low_q > TrackLim || sector_q > SectorLim) begin
                      op_d = dctf_pkg::OP_NONE;
                    end else begin
                      op_d              = dctf_pkg::OP_READ;
                      ready_d           = 1'b0;
                      pend_d            = dctf_pkg::XFER_READ;
                      s1_d.disk_request = dctf_pkg::XFER_READ;
                      s1_d.disk_drive   = sel_drive;
                      s1_d.disk_offset  = lin_offset;
                    end
                  end
                  dctf_pkg::CmdWrite: begin
                    op_d   = dctf_pkg::OP_WRITE;
                    bp_d   = '0;
                    seek_d = 1'b1;
                    drq_d  = 1'b1;
                  end
                  default: begin
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end

        dctf_pkg::ITEM_REG_READ: begin
          if (reg_index_i == dctf_pkg::REG_TRACK_HIGH ||
              reg_index_i == dctf_pkg::REG_SDH) begin
            s1_d.read_data = 8'd0;
          end else if (!sel_present) begin
            s1_d.read_data = dctf_pkg::AbsentValue;
          end else begin
            unique case (dctf_pkg::reg_idx_e'(reg_index_i))
              dctf_pkg::REG_DATA: begin
                if (bp_q < FullPtr) begin
                  mem_re   = 1'b1;
                  s1_mem_d = 1'b1;
                  bp_d     = bp_inc;
                  if (bp_inc >= FullPtr) begin
                    drq_d = 1'b0;
                    op_d  = dctf_pkg::OP_NONE;
                  end
                end
              end
              dctf_pkg::REG_COUNT:     s1_d.read_data = count_q;
              dctf_pkg::REG_SECTOR:    s1_d.read_data = sector_q;
              dctf_pkg::REG_TRACK_LOW: s1_d.read_data = track_low_q;
              dctf_pkg::REG_STATUS:    s1_d.read_data = status_val;
              default:                 s1_d.read_data = 8'd0;
            endcase
          end
        end

        dctf_pkg::ITEM_DISK_FILL: begin
          if (pend_q == dctf_pkg::XFER_READ && tp_q < FullPtr) begin
            item_we = 1'b1;
            item_wa = tp_q[AddrW-1:0];
            tp_d    = tp_inc;
          end
        end

        dctf_pkg::ITEM_DISK_DRAIN: begin
          if (pend_q == dctf_pkg::XFER_WRITE && tp_q < FullPtr) begin
            mem_re   = 1'b1;
            mem_ra   = tp_q[AddrW-1:0];
            s1_mem_d = 1'b1;
            tp_d     = tp_inc;
          end
        end

        dctf_pkg::ITEM_DISK_DONE: begin
          if (pend_q == dctf_pkg::XFER_READ) begin
            if (disk_ok_i && tp_q >= FullPtr) begin
              ready_d = 1'b1;
              bp_d    = '0;
              seek_d  = 1'b1;
              drq_d   = 1'b1;
            end else begin
              op_d = dctf_pkg::OP_NONE;
            end
          end else if (pend_q == dctf_pkg::XFER_WRITE) begin
            if (!(disk_ok_i && tp_q >= FullPtr)) ready_d = 1'b0;
          end
          pend_d = dctf_pkg::XFER_NONE;
          tp_d   = '0;
        end

        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sector buffer: clearing pass shares the write port
  // --------------------------------------------------------------------------
  assign mem_we = clr_busy_q || item_we;
  assign mem_wa = clr_busy_q ? clr_cnt_q : item_wa;
  assign mem_wd = clr_busy_q ? 8'(clr_cnt_q) : item_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == LastAddr) clr_busy_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Task-file and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q         <= '0;
      tp_q         <= '0;
      op_q         <= dctf_pkg::OP_NONE;
      pend_q       <= dctf_pkg::XFER_NONE;
      track_low_q  <= '0;
      track_high_q <= '0;
      sector_q     <= '0;
      count_q      <= '0;
      sdh_q        <= '0;
      cmd_code_q   <= '0;
      precomp_q    <= '0;
      ready_q      <= 1'b1;
      drq_q        <= 1'b0;
      seek_q       <= 1'b0;
    end else begin
      bp_q         <= bp_d;
      tp_q         <= tp_d;
      op_q         <= op_d;
      pend_q       <= pend_d;
      track_low_q  <= track_low_d;
      track_high_q <= track_high_d;
      sector_q     <= sector_d;
      count_q      <= count_d;
      sdh_q        <= sdh_d;
      cmd_code_q   <= cmd_code_d;
      precomp_q    <= precomp_d;
      ready_q      <= ready_d;
      drq_q        <= drq_d;
      seek_q       <= seek_d;
    end
  end

  // drive-present configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive0_q <= 1'b0;
      drive1_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == dctf_pkg::CfgDrive0) drive0_q <= cfg_data_i;
      if (cfg_index_i == dctf_pkg::CfgDrive1) drive1_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Result stages: stage one waits on the buffer read, stage two drives out
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q     <= s1_d;
      s1_mem_q <= s1_mem_d;
    end
    if (s2_load) begin
      out_q.read_data    <= s1_mem_q ? rd_q : s1_q.read_data;
      out_q.disk_request <= s1_q.disk_request;
      out_q.disk_drive   <= s1_q.disk_drive;
      out_q.disk_offset  <= s1_q.disk_offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_q.read_data;
  assign disk_request_o = out_q.disk_request;
  assign disk_drive_o   = out_q.disk_drive;
  assign disk_offset_o  = out_q.disk_offset;

endmodule
